// File: design/ugb_pkg.sv
`default_nettype none
package ugb_pkg;
   localparam int DEF_MAX_BLOCKS = 64;
   localparam int DEF_MAX_COLS   = 32;
   localparam int DEF_MAX_ROWS   = 32;
   localparam int CNT_W          = 11;
   localparam int CNT_MAX        = 2047;
   localparam int PIX_W          = 13;
   localparam int QDEPTH         = 2;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_DEACT = 2'd3
   } action_type;

   localparam logic [1:0] CSR_SHIFT = 2'd0;
   localparam logic [1:0] CSR_COLS  = 2'd1;
   localparam logic [1:0] CSR_ROWS  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_WAIT,
      ST_MERGE,
      ST_DONE
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [5:0]  block_id;
      logic        empty;
      logic [6:0]  x0;
      logic [6:0]  x1;
      logic [6:0]  y0;
      logic [6:0]  y1;
   } cmd_type;

   function automatic logic signed [PIX_W+1:0] div_trunc(
      input logic signed [PIX_W+1:0] v, input logic [3:0] s);
      logic [PIX_W+1:0] m;
      begin
         m = v[PIX_W+1] ? -v : v;
         m = m >> s;
         div_trunc = v[PIX_W+1] ? -$signed(m) : $signed(m);
      end
   endfunction
endpackage
`default_nettype wire

// File: design/ugb_ram.sv
`default_nettype none
module ugb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/ugb_front.sv
`default_nettype none
module ugb_front #(
   parameter int MAX_COLS = ugb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ugb_pkg::DEF_MAX_ROWS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire logic [1:0]      action,
   input  wire logic [5:0]      block_id,
   input  wire logic [12:0]     rect_left,
   input  wire logic [12:0]     rect_top,
   input  wire logic [11:0]     rect_width,
   input  wire logic [11:0]     rect_height,
   input  wire logic [3:0]      cell_shift,
   input  wire logic [5:0]      grid_cols,
   input  wire logic [5:0]      grid_rows,
   output logic                 cmd_valid,
   input  wire logic            cmd_ready,
   output ugb_pkg::cmd_type     cmd
);
   import ugb_pkg::*;

   cmd_type             q_ff [QDEPTH];
   cmd_type             c_in;
   logic [1:0]          cnt_ff;
   logic                wp_ff, rp_ff;
   logic signed [14:0]  a, b, c, d, lx, ly;
   logic                push, pop;

   always_comb begin
      lx = ({1'b0, grid_cols} > 7'(MAX_COLS)) ? 15'(MAX_COLS - 1) :
           $signed({9'd0, grid_cols}) - 15'sd1;
      ly = ({1'b0, grid_rows} > 7'(MAX_ROWS)) ? 15'(MAX_ROWS - 1) :
           $signed({9'd0, grid_rows}) - 15'sd1;
      a = div_trunc(15'(signed'(rect_left)), cell_shift);
      b = div_trunc(15'(signed'(rect_left)) + $signed({3'd0, rect_width}), cell_shift);
      c = div_trunc(15'(signed'(rect_top)), cell_shift);
      d = div_trunc(15'(signed'(rect_top)) + $signed({3'd0, rect_height}), cell_shift);
      if (a < 0) a = '0;
      if (c < 0) c = '0;
      if (b > lx) b = lx;
      if (d > ly) d = ly;
      c_in.action   = action_type'(action);
      c_in.block_id = block_id;
      c_in.empty    = (b < a) || (d < c);
      c_in.x0 = a[6:0];
      c_in.x1 = b[6:0];
      c_in.y0 = c[6:0];
      c_in.y1 = d[6:0];
   end

   assign in_ready  = cnt_ff != 2'(QDEPTH);
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) q_ff[wp_ff] <= c_in;
   end

`ifndef ASSERT_OFF
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QDEPTH))
      else $error("queue overflow");
   a_nopush_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'(QDEPTH) && !pop |=> cnt_ff == 2'(QDEPTH))
      else $error("queue lost word");
   a_empty_ptr: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> wp_ff == rp_ff)
      else $error("pointer mismatch");
`endif
endmodule
`default_nettype wire

// File: design/ugb_back.sv
`default_nettype none
module ugb_back #(
   parameter int MAX_BLOCKS = ugb_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_COLS   = ugb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = ugb_pkg::DEF_MAX_ROWS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   output logic                      cmd_ready,
   input  wire ugb_pkg::cmd_type     cmd,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [63:0]               candidates,
   output logic [ugb_pkg::CNT_W-1:0] cells_covered
);
   import ugb_pkg::*;

   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DEPTH = 1 << (CW + RW);
   localparam int AW    = CW + RW;

   state_type            st_ff, st_in;
   cmd_type              c_ff, c_in;
   logic [6:0]           x_ff, x_in, y_ff, y_in;
   logic [AW:0]          clr_ff, clr_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [63:0]          acc_ff, acc_in, act_ff, act_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 ov_ff, ov_in;
   logic [63:0]          cand_ff, cand_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr, cur_addr;
   logic [63:0]          wr_data, rd_data, bit_m;
   logic                 last;

   assign bit_m = (32'(c_ff.block_id) < MAX_BLOCKS) ? (64'd1 << c_ff.block_id) : 64'd0;
   assign cur_addr = {y_ff[RW-1:0], x_ff[CW-1:0]};
   assign last = (x_ff == c_ff.x1) && (y_ff == c_ff.y1);

   ugb_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         act_ff     <= '0;
         out_valid  <= 1'b0;
      end else begin
         st_ff      <= st_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         act_ff     <= act_in;
         if (st_ff == ST_DONE) out_valid <= 1'b1;
         else if (out_ready) out_valid <= 1'b0;
      end
      c_ff <= c_in; x_ff <= x_in; y_ff <= y_in;
      acc_ff <= acc_in; n_ff <= n_in; ov_ff <= ov_in;
      cand_ff <= cand_in; cnt_ff <= cnt_in;
      if (st_ff == ST_DONE) begin
         candidates    <= cand_ff;
         cells_covered <= cnt_ff;
      end
   end

   always_comb begin
      st_in = st_ff; c_in = c_ff; x_in = x_ff; y_in = y_ff; clr_in = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      acc_in = acc_ff; n_in = n_ff; ov_in = ov_ff; act_in = act_ff;
      cand_in = cand_ff; cnt_in = cnt_ff;
      cmd_ready = 1'b0; wr_en = 1'b0; wr_addr = cur_addr; wr_data = rd_data | bit_m;
      rd_addr = cur_addr;
      case (st_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) begin
               st_in      = clr_rsp_ff ? ST_DONE : ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            cmd_ready = !out_valid || out_ready;
            if (cmd_valid && cmd_ready) begin
               c_in = cmd; x_in = cmd.x0; y_in = cmd.y0;
               acc_in = '0; n_in = '0; ov_in = 1'b0;
               case (cmd.action)
                  ACT_CLEAR: begin
                     clr_in = '0; clr_rsp_in = 1'b1; st_in = ST_CLEAR;
                     cand_in = '0; cnt_in = '0;
                  end
                  ACT_DEACT: begin
                     act_in = act_ff & ~((32'(cmd.block_id) < MAX_BLOCKS) ?
                        (64'd1 << cmd.block_id) : 64'd0);
                     cand_in = '0; cnt_in = '0; st_in = ST_DONE;
                  end
                  default: begin
                     if (cmd.empty) begin
                        if (cmd.action == ACT_INSERT) act_in = act_ff |
                           ((32'(cmd.block_id) < MAX_BLOCKS) ? (64'd1 << cmd.block_id) : 64'd0);
                        cand_in = '0; cnt_in = '0; st_in = ST_DONE;
                     end else begin
                        st_in = ST_WAIT;
                     end
                  end
               endcase
            end
         end
         ST_WAIT: st_in = ST_MERGE;
         ST_MERGE: begin
            if (c_ff.action == ACT_INSERT) wr_en = 1'b1;
            acc_in = acc_ff | rd_data;
            if (n_ff == CNT_W'(CNT_MAX)) ov_in = 1'b1;
            n_in = n_ff + 1'b1;
            if (last) begin
               if (c_ff.action == ACT_INSERT) begin
                  act_in = act_ff | bit_m; cand_in = '0;
               end else begin
                  cand_in = (acc_ff | rd_data) & act_ff;
               end
               cnt_in = (ov_ff || n_ff == CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : n_ff + 1'b1;
               st_in = ST_DONE;
            end else begin
               if (y_ff == c_ff.y1) begin
                  y_in = c_ff.y0; x_in = x_ff + 1'b1;
               end else begin
                  y_in = y_ff + 1'b1;
               end
               st_in = ST_WAIT;
            end
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_WAIT) rd_addr = cur_addr;
   end

`ifndef ASSERT_OFF
   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !cmd_ready) else $error("took word while busy");
   a_done: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_DONE |=> out_valid) else $error("result lost");
   a_clear_wr: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_CLEAR |-> wr_en && wr_data == 64'd0) else $error("clear write");
`endif
endmodule
`default_nettype wire

// File: design/uniform_grid_broadphase.sv
`default_nettype none
// Uniform grid broad phase: a front stage turns each rectangle into a clamped
// cell range and queues it; a back stage walks the range through a two-port
// 64-bit cell RAM, covered cell by covered cell (read, then merge or write back).
// Clear and reset sweep the whole RAM, one cell a cycle (1024 cells at default
// size), while no word is taken.
module uniform_grid_broadphase #(
   parameter int MAX_BLOCKS = ugb_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_COLS   = ugb_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = ugb_pkg::DEF_MAX_ROWS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[1:0] block_id[7:2] rect_left[20:8] rect_top[33:21]
   // rect_width[45:34] rect_height[57:46]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // candidates[63:0] cells_covered[74:64]
   output logic [79:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_wdata
);
   import ugb_pkg::*;

   logic [3:0]  shift_ff;
   logic [5:0]  cols_ff, rows_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd;
   logic [63:0] cand;
   logic [CNT_W-1:0] cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 4'd5; cols_ff <= 6'd25; rows_ff <= 6'd20;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SHIFT: shift_ff <= csr_wdata[3:0];
            CSR_COLS:  cols_ff  <= csr_wdata;
            CSR_ROWS:  rows_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   ugb_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .action(req_tdata[1:0]), .block_id(req_tdata[7:2]),
      .rect_left(req_tdata[20:8]), .rect_top(req_tdata[33:21]),
      .rect_width(req_tdata[45:34]), .rect_height(req_tdata[57:46]),
      .cell_shift(shift_ff), .grid_cols(cols_ff), .grid_rows(rows_ff),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

   ugb_back #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd(cmd), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .candidates(cand), .cells_covered(cnt));

   assign rsp_tdata = {5'd0, cnt, cand};
endmodule
`default_nettype wire

// File: test/tb_uniform_grid_broadphase.sv
`default_nettype none
module tb_uniform_grid_broadphase;
   timeunit 1ns;
   timeprecision 1ps;
   import ugb_pkg::*;

   typedef struct {
      logic [63:0] candidates;
      logic [10:0] cells;
   } grid_result_type;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_wdata = '0;

   logic [63:0] cell_mask [0:1023];
   logic [63:0] live_mask;
   logic [3:0]  shift_q;
   logic [5:0]  cols_q;
   logic [5:0]  rows_q;

   grid_result_type pending_q[$];
   int mismatches = 0;
   int words_sent = 0;
   int words_seen = 0;
   int query_hits = 0;
   int sender_gap_max = 11;
   int rsp_wait = 0;
   int seen_prev = 0;
   bit stall_off = 1'b0;

   uniform_grid_broadphase uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int trunc_shift(int v, int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   task automatic clamp_span(input int lo_px, input int hi_px, input int n,
                             output int lo, output int hi);
      int lim;
      lim = (n > 32 ? 32 : n) - 1;
      lo = trunc_shift(lo_px, shift_q);
      hi = trunc_shift(hi_px, shift_q);
      if (lo < 0) lo = 0;
      if (hi > lim) hi = lim;
   endtask

   task automatic grid_predict(input logic [63:0] w);
      action_type  act;
      logic [5:0]  id;
      int          left, top, wd, ht, x0, x1, y0, y1, cnt;
      logic [63:0] bit_m, cand;
      grid_result_type r;
      act = action_type'(w[1:0]);
      id = w[7:2];
      left = $signed(w[20:8]);
      top = $signed(w[33:21]);
      wd = w[45:34];
      ht = w[57:46];
      bit_m = 64'd1 << id;
      cand = '0;
      cnt = 0;
      case (act)
         ACT_CLEAR: begin
            foreach (cell_mask[i]) cell_mask[i] = '0;
         end
         ACT_DEACT: begin
            live_mask &= ~bit_m;
         end
         default: begin
            clamp_span(left, left + wd, cols_q, x0, x1);
            clamp_span(top, top + ht, rows_q, y0, y1);
            for (int x = x0; x <= x1; x++)
               for (int y = y0; y <= y1; y++) begin
                  if (act == ACT_INSERT) cell_mask[y * 32 + x] |= bit_m;
                  else cand |= cell_mask[y * 32 + x];
                  cnt++;
               end
            if (act == ACT_INSERT) live_mask |= bit_m;
            else cand &= live_mask;
         end
      endcase
      if (cnt > CNT_MAX) cnt = CNT_MAX;
      if (cand != 0) query_hits++;
      r.candidates = cand;
      r.cells = cnt[10:0];
      pending_q = {pending_q, r};
   endtask

   task automatic send_word(input action_type act, input logic [5:0] id,
                            input int left, input int top, input int wd, input int ht);
      logic [63:0] w;
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      w = '0;
      w[1:0] = act;
      w[7:2] = id;
      w[20:8] = left[12:0];
      w[33:21] = top[12:0];
      w[45:34] = wd[11:0];
      w[57:46] = ht[11:0];
      req_tdata <= w;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      grid_predict(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [5:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SHIFT) shift_q = val[3:0];
      else if (idx == CSR_COLS) cols_q = val;
      else if (idx == CSR_ROWS) rows_q = val;
   endtask

   task automatic set_grid(input int s, input int c, input int r);
      drain();
      csr_write(CSR_SHIFT, s[5:0]);
      csr_write(CSR_COLS, c[5:0]);
      csr_write(CSR_ROWS, r[5:0]);
   endtask

   // hold tready low for a drawn number of cycles after each word, unless stall_off is set
   always @(negedge clock) begin
      if (words_seen != seen_prev) begin
         seen_prev = words_seen;
         rsp_wait = $urandom_range(0, 11);
      end
      if (stall_off || rsp_wait == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end
   end

   always @(posedge clock) begin
      grid_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: cand=%h cells=%0d",
                        rsp_tdata[63:0], rsp_tdata[74:64]);
         end else begin
            e = pending_q.pop_front();
            if (rsp_tdata[63:0] !== e.candidates || rsp_tdata[74:64] !== e.cells) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp cand=%h cells=%0d, got cand=%h cells=%0d",
                           e.candidates, e.cells, rsp_tdata[63:0], rsp_tdata[74:64]);
            end
         end
      end
   end

   task automatic random_rect(output int left, output int top,
                              output int wd, output int ht);
      int span_px;
      span_px = (32 << shift_q);
      if ($urandom_range(0, 9) == 0) begin
         left = $signed(13'($urandom));
         top = $signed(13'($urandom));
         wd = $urandom_range(0, 4095);
         ht = $urandom_range(0, 4095);
      end else begin
         left = $urandom_range(0, span_px > 4000 ? 4000 : span_px) - 64;
         top = $urandom_range(0, span_px > 4000 ? 4000 : span_px) - 64;
         wd = $urandom_range(0, 3 << shift_q);
         ht = $urandom_range(0, 3 << shift_q);
         if (wd > 4095) wd = 4095;
         if (ht > 4095) ht = 4095;
      end
   endtask

   task automatic test_directed;
      send_word(ACT_QUERY, 6'd0, 0, 0, 0, 0);
      send_word(ACT_INSERT, 6'd0, 0, 0, 0, 0);
      send_word(ACT_INSERT, 6'd63, -4096, -4096, 4095, 4095);
      send_word(ACT_INSERT, 6'd5, 4095, 4095, 4095, 4095);
      send_word(ACT_QUERY, 6'd63, -4096, -4096, 4095, 4095);
      send_word(ACT_QUERY, 6'd0, 0, 0, 4095, 4095);
      send_word(ACT_DEACT, 6'd63, 0, 0, 0, 0);
      send_word(ACT_QUERY, 6'd0, 0, 0, 100, 100);
      send_word(ACT_INSERT, 6'd63, 200, 200, 10, 10);
      send_word(ACT_QUERY, 6'd42, -1, -1, 1, 1);
      send_word(ACT_CLEAR, 6'd21, 0, 0, 0, 0);
      send_word(ACT_QUERY, 6'd0, -4096, -4096, 4095, 4095);
      send_word(ACT_INSERT, 6'd7, -40, -40, 10, 10);
      send_word(ACT_QUERY, 6'd7, -40, -40, 10, 10);
      send_word(ACT_DEACT, 6'd7, 0, 0, 0, 0);
      send_word(ACT_QUERY, 6'd7, 0, 0, 64, 64);
   endtask

   task automatic test_grid_extremes;
      set_grid(0, 32, 32);
      send_word(ACT_INSERT, 6'd1, 0, 0, 4095, 4095);
      send_word(ACT_QUERY, 6'd0, 31, 31, 0, 0);
      set_grid(15, 63, 63);
      send_word(ACT_INSERT, 6'd2, 4095, -4096, 4095, 4095);
      send_word(ACT_QUERY, 6'd0, -4096, -4096, 4095, 4095);
      set_grid(10, 0, 5);
      send_word(ACT_INSERT, 6'd3, 0, 0, 4095, 4095);
      send_word(ACT_QUERY, 6'd0, 0, 0, 4095, 4095);
      set_grid(3, 1, 1);
      csr_write(CSR_UNUSED, 6'h3f);
      send_word(ACT_QUERY, 6'd0, 0, 0, 4095, 4095);
   endtask

   task automatic test_random(input int n);
      int left, top, wd, ht, r;
      for (int i = 0; i < n; i++) begin
         random_rect(left, top, wd, ht);
         r = $urandom_range(0, 99);
         if (r < 2) send_word(ACT_CLEAR, 6'($urandom), left, top, wd, ht);
         else if (r < 12) send_word(ACT_DEACT, 6'($urandom), left, top, wd, ht);
         else if (r < 55) send_word(ACT_INSERT, 6'($urandom), left, top, wd, ht);
         else send_word(ACT_QUERY, 6'($urandom), left, top, wd, ht);
      end
   endtask

   initial begin
      foreach (cell_mask[i]) cell_mask[i] = '0;
      live_mask = '0;
      shift_q = 4'd5;
      cols_q = 6'd25;
      rows_q = 6'd20;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_grid_extremes();
      set_grid(5, 25, 20);
      test_random(400);
      set_grid(2, 32, 32);
      test_random(400);
      set_grid(7, 12, 9);
      sender_gap_max = 0;
      stall_off = 1'b1;
      test_random(300);
      stall_off = 1'b0;
      sender_gap_max = 11;
      set_grid(0, 40, 3);
      test_random(300);
      set_grid(4, 17, 32);
      test_random(400);
      drain();
      $display("sent %0d words, checked %0d results, %0d queries found candidates",
               words_sent, words_seen, query_hits);
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
design/ugb_pkg.sv
design/ugb_ram.sv
design/ugb_front.sv
design/ugb_back.sv
design/uniform_grid_broadphase.sv
test/tb_uniform_grid_broadphase.sv
